### design/assert_macros.svh
// Assertion macros shared by the RTL; clock i_clk, reset i_rst_n active low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/vss_pkg.sv
// Package for the versioned stack store: sizes, status and operation codes.
`timescale 1ns / 1ps

package vss_pkg;

    localparam int VSS_MAX_VERSIONS = 4096;
    localparam int VSS_VALUE_BITS   = 16;
    localparam int VSS_VER_BITS     = 12;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_BAD_VERSION = 2'd1;
    localparam t_status ST_EMPTY       = 2'd2;
    localparam t_status ST_FULL        = 2'd3;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

endpackage

### design/vss_stream_if.sv
// Request and response channel interfaces of the versioned stack store.
`timescale 1ns / 1ps

interface vss_req_if #(
    parameter int VALUE_BITS = vss_pkg::VSS_VALUE_BITS
);
    import vss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [VSS_VER_BITS-1:0] version;
    logic [VALUE_BITS-1:0]   value;

    modport source (output valid, kind, version, value, input ready);
    modport sink   (input valid, kind, version, value, output ready);
endinterface

interface vss_rsp_if #(
    parameter int VALUE_BITS = vss_pkg::VSS_VALUE_BITS
);
    import vss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [VSS_VER_BITS-1:0] new_version;
    logic [VALUE_BITS-1:0]   popped_value;
    t_status                 status;

    modport source (output valid, new_version, popped_value, status, input ready);
    modport sink   (input valid, new_version, popped_value, status, output ready);
endinterface

### design/versioned_stack_store.sv
// Push or error: request accept, S_TOP, then the result register. Pop: accept, S_TOP,
// S_NODE, then the result register. A new request is taken only in S_IDLE; the dependent
// reads of the version-top memory and then the node memory are registered.
// A waiting result does not block the next request; only its completion waits.
// Reset (synchronous, active low) sets one version and one node; no memory clearing,
// version 0 reads as the empty stack whatever the version-top memory holds.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module versioned_stack_store #(
    parameter int MAX_VERSIONS = vss_pkg::VSS_MAX_VERSIONS,
    parameter int VALUE_BITS   = vss_pkg::VSS_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vss_req_if.sink   i_req,
    vss_rsp_if.source o_rsp
);
    import vss_pkg::*;

    localparam int IW = $clog2(MAX_VERSIONS);
    localparam int NW = IW + 1;
    localparam int CW = (NW > VSS_VER_BITS) ? NW : VSS_VER_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TOP  = 2'd1;
    localparam logic [1:0] S_NODE = 2'd2;

    localparam logic [NW-1:0] MAX_CNT = NW'(MAX_VERSIONS);

    // version-top and node memories
    logic [IW-1:0]            r_vt_mem [MAX_VERSIONS];
    logic [IW+VALUE_BITS-1:0] r_ns_mem [MAX_VERSIONS];
    logic [IW-1:0]            r_vt_rd;
    logic [IW+VALUE_BITS-1:0] r_ns_rd;

    logic [1:0]              r_state, n_state;
    logic                    r_kind;
    logic [VSS_VER_BITS-1:0] r_ver;
    logic [VALUE_BITS-1:0]   r_val;
    logic [NW-1:0]           r_vcount, n_vcount;
    logic [NW-1:0]           r_ncount, n_ncount;

    logic                    r_out_valid, n_out_valid;
    logic [VSS_VER_BITS-1:0] r_out_nv;
    logic [VALUE_BITS-1:0]   r_out_pop;
    t_status                 r_out_st;

    logic                    w_accept;
    logic [CW-1:0]           w_in_ver_ext;
    logic [CW-1:0]           w_ver_ext;
    logic [CW-1:0]           w_vc_ext;
    logic [IW-1:0]           w_top;
    t_status                 w_st;
    logic                    w_slot;
    logic                    w_load;
    logic [VSS_VER_BITS-1:0] w_nv;
    logic [VALUE_BITS-1:0]   w_pop;
    logic                    w_vt_we;
    logic [IW-1:0]           w_vt_wdata;
    logic                    w_ns_we;
    logic                    w_ns_re;

    assign i_req.ready  = (r_state == S_IDLE);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_in_ver_ext = CW'(i_req.version);
    assign w_ver_ext    = CW'(r_ver);
    assign w_vc_ext     = CW'(r_vcount);
    assign w_top        = (r_ver == '0) ? '0 : r_vt_rd;
    assign w_slot       = !r_out_valid || o_rsp.ready;
    assign w_nv         = w_vc_ext[VSS_VER_BITS-1:0];

    // checks in order: unknown version, empty pop, full store
    always_comb begin
        if (w_ver_ext >= w_vc_ext) begin
            w_st = ST_BAD_VERSION;
        end else if (r_kind == KIND_POP && w_top == '0) begin
            w_st = ST_EMPTY;
        end else if (r_vcount == MAX_CNT || (r_kind == KIND_PUSH && r_ncount == MAX_CNT)) begin
            w_st = ST_FULL;
        end else begin
            w_st = ST_OK;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_vcount    = r_vcount;
        n_ncount    = r_ncount;
        w_load      = 1'b0;
        w_vt_we     = 1'b0;
        w_vt_wdata  = w_top;
        w_ns_we     = 1'b0;
        w_ns_re     = 1'b0;
        w_pop       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                if (w_st == ST_OK && r_kind == KIND_POP) begin
                    w_ns_re = 1'b1;
                    n_state = S_NODE;
                end else if (w_slot) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (w_st == ST_OK) begin
                        w_ns_we    = 1'b1;
                        w_vt_we    = 1'b1;
                        w_vt_wdata = r_ncount[IW-1:0];
                        n_ncount   = r_ncount + 1'b1;
                        n_vcount   = r_vcount + 1'b1;
                    end
                end
            end
            S_NODE: begin
                w_pop = r_ns_rd[VALUE_BITS-1:0];
                if (w_slot) begin
                    w_load     = 1'b1;
                    w_vt_we    = 1'b1;
                    w_vt_wdata = r_ns_rd[IW+VALUE_BITS-1:VALUE_BITS];
                    n_vcount   = r_vcount + 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vt_we) begin
            r_vt_mem[r_vcount[IW-1:0]] <= w_vt_wdata;
        end
        if (w_accept) begin
            r_vt_rd <= r_vt_mem[w_in_ver_ext[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ns_we) begin
            r_ns_mem[r_ncount[IW-1:0]] <= {w_top, r_val};
        end
        if (w_ns_re) begin
            r_ns_rd <= r_ns_mem[w_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= NW'(1);
            r_ncount    <= NW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcount    <= n_vcount;
            r_ncount    <= n_ncount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_req.kind;
            r_ver  <= i_req.version;
            r_val  <= i_req.value;
        end
        if (w_load) begin
            r_out_st  <= w_st;
            r_out_nv  <= (w_st == ST_OK) ? w_nv : '0;
            r_out_pop <= (w_st == ST_OK) ? w_pop : '0;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.new_version  = r_out_nv;
    assign o_rsp.popped_value = r_out_pop;
    assign o_rsp.status       = r_out_st;

    // every node but the sentinel came with a version of its own
    `ASSERT_IMP(a_cnt_order, 1'b1, r_ncount <= r_vcount)
    `ASSERT_NXT(a_push_cnt, w_load && r_kind == KIND_PUSH && w_st == ST_OK, r_ncount == $past(r_ncount) + 1'b1)
    `ASSERT_NXT(a_err_hold, w_load && w_st != ST_OK, r_vcount == $past(r_vcount) && r_ncount == $past(r_ncount))

endmodule

### dv/versioned_stack_store_tb.sv
// Self-checking testbench for the versioned stack store: directed table, then random ops.
`timescale 1ns / 1ps

module versioned_stack_store_tb;
    import vss_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_OPS     = 1080;
    localparam int TAIL_OPS       = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [VSS_VER_BITS-1:0]   new_version;
        logic [VSS_VALUE_BITS-1:0] popped_value;
        t_status                   status;
    } stack_rsp_t;

    typedef struct packed {
        logic                      kind;
        logic [VSS_VER_BITS-1:0]   version;
        logic [VSS_VALUE_BITS-1:0] value;
        logic                      typed;
        stack_rsp_t                rsp;
    } op_row_t;

    logic i_clk;
    logic i_rst_n;

    vss_req_if req_bus ();
    vss_rsp_if rsp_bus ();

    versioned_stack_store DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow of the stack store
    logic [VSS_VER_BITS-1:0]   ver_top_pred [VSS_MAX_VERSIONS];
    logic [VSS_VER_BITS-1:0]   node_link    [VSS_MAX_VERSIONS];
    logic [VSS_VALUE_BITS-1:0] node_data    [VSS_MAX_VERSIONS];
    int                        versions_made;
    int                        nodes_made;

    stack_rsp_t pending_rsp [$];
    op_row_t    op_table [$];
    int         mismatch_count;
    int         rsp_seen;
    int         quiet_cycles;
    bit         req_idle_on;
    bit         rsp_stall_on;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Apply one request to the shadow state and return the response it yields.
    function automatic stack_rsp_t apply_stack_op(logic kind, logic [VSS_VER_BITS-1:0] ver,
                                                  logic [VSS_VALUE_BITS-1:0] val);
        stack_rsp_t              r;
        logic [VSS_VER_BITS-1:0] top;
        r = '{new_version: '0, popped_value: '0, status: ST_OK};
        if (int'(ver) >= versions_made) begin
            r.status = ST_BAD_VERSION;
        end else begin
            top = ver_top_pred[ver];
            if (kind == KIND_POP && top == '0) begin
                r.status = ST_EMPTY;
            end else if (versions_made >= VSS_MAX_VERSIONS ||
                         (kind == KIND_PUSH && nodes_made >= VSS_MAX_VERSIONS)) begin
                r.status = ST_FULL;
            end else if (kind == KIND_PUSH) begin
                node_link[nodes_made]       = top;
                node_data[nodes_made]       = val;
                r.new_version               = versions_made[VSS_VER_BITS-1:0];
                ver_top_pred[versions_made] = nodes_made[VSS_VER_BITS-1:0];
                nodes_made++;
                versions_made++;
            end else begin
                r.popped_value              = node_data[top];
                r.new_version               = versions_made[VSS_VER_BITS-1:0];
                ver_top_pred[versions_made] = node_link[top];
                versions_made++;
            end
        end
        return r;
    endfunction

    function automatic void add_row(op_row_t row);
        op_table = {op_table, row};
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] response %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, rsp_seen, what, got, want);
        mismatch_count++;
    endtask

    // Drive one request; typed rows supply their own expectation.
    task automatic send_req(logic kind, logic [VSS_VER_BITS-1:0] ver,
                            logic [VSS_VALUE_BITS-1:0] val, logic typed, stack_rsp_t want);
        stack_rsp_t predicted;
        @(negedge i_clk);
        if (req_idle_on && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.kind    <= kind;
        req_bus.version <= ver;
        req_bus.value   <= val;
        do @(posedge i_clk); while (!req_bus.ready);
        predicted = apply_stack_op(kind, ver, val);
        if (typed)
            predicted = want;
        pending_rsp = {pending_rsp, predicted};
    endtask

    task automatic send_random(bit allow_unknown);
        int                        pick;
        int                        span;
        logic                      kind;
        logic [VSS_VER_BITS-1:0]   ver;
        logic [VSS_VALUE_BITS-1:0] val;
        pick = $urandom_range(0, 99);
        span = (versions_made > 8) ? 7 : versions_made - 1;
        if (allow_unknown && pick < 10 && versions_made < VSS_MAX_VERSIONS)
            ver = VSS_VER_BITS'($urandom_range(versions_made, VSS_MAX_VERSIONS - 1));
        else if (pick < 50)
            ver = VSS_VER_BITS'(versions_made - 1 - $urandom_range(0, span));
        else if (pick < 58)
            ver = '0;
        else
            ver = VSS_VER_BITS'($urandom_range(0, versions_made - 1));
        kind = ($urandom_range(0, 99) < 45) ? KIND_POP : KIND_PUSH;
        case ($urandom_range(0, 9))
            0: val = '0;
            1: val = '1;
            default: val = VSS_VALUE_BITS'($urandom());
        endcase
        send_req(kind, ver, val, 1'b0, '0);
    endtask

    // Response ready with random stall bursts
    initial begin
        rsp_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Response checker
    always @(posedge i_clk) begin
        stack_rsp_t got;
        stack_rsp_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got = '{new_version: rsp_bus.new_version, popped_value: rsp_bus.popped_value,
                    status: rsp_bus.status};
            if (pending_rsp.size() == 0) begin
                report_mismatch("outstanding requests", 0, 1);
            end else begin
                want = pending_rsp.pop_front();
                if (got.new_version !== want.new_version)
                    report_mismatch("new_version", 32'(got.new_version),
                                    32'(want.new_version));
                if (got.popped_value !== want.popped_value)
                    report_mismatch("popped_value", 32'(got.popped_value),
                                    32'(want.popped_value));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
            rsp_seen++;
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL versioned_stack_store");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.kind    = KIND_PUSH;
        req_bus.version = '0;
        req_bus.value   = '0;
        mismatch_count  = 0;
        rsp_seen        = 0;
        quiet_cycles    = 0;
        req_idle_on     = 1'b1;
        rsp_stall_on    = 1'b1;
        versions_made   = 1;
        nodes_made      = 1;
        for (int i = 0; i < VSS_MAX_VERSIONS; i++) begin
            ver_top_pred[i] = '0;
            node_link[i]    = '0;
            node_data[i]    = '0;
        end

        //      kind       version   value      typed  new_ver popped   status
        add_row('{KIND_POP,  12'd0,    16'h0000, 1'b1, '{12'd0, 16'h0000, ST_EMPTY}});
        add_row('{KIND_PUSH, 12'd1,    16'hFFFF, 1'b1,
                  '{12'd0, 16'h0000, ST_BAD_VERSION}});
        add_row('{KIND_POP,  12'd4095, 16'hFFFF, 1'b1,
                  '{12'd0, 16'h0000, ST_BAD_VERSION}});
        add_row('{KIND_PUSH, 12'd0,    16'hFFFF, 1'b1, '{12'd1, 16'h0000, ST_OK}});
        // value is a don't-care on a pop
        add_row('{KIND_POP,  12'd1,    16'h1234, 1'b1, '{12'd2, 16'hFFFF, ST_OK}});
        add_row('{KIND_POP,  12'd2,    16'h0000, 1'b1, '{12'd0, 16'h0000, ST_EMPTY}});
        add_row('{KIND_PUSH, 12'd1,    16'h0000, 1'b1, '{12'd3, 16'h0000, ST_OK}});
        add_row('{KIND_PUSH, 12'd3,    16'h8000, 1'b1, '{12'd4, 16'h0000, ST_OK}});
        add_row('{KIND_PUSH, 12'd4,    16'h0001, 1'b1, '{12'd5, 16'h0000, ST_OK}});
        add_row('{KIND_POP,  12'd5,    16'hFFFF, 1'b1, '{12'd6, 16'h0001, ST_OK}});
        add_row('{KIND_POP,  12'd6,    16'h0000, 1'b1, '{12'd7, 16'h8000, ST_OK}});
        add_row('{KIND_POP,  12'd7,    16'h0000, 1'b1, '{12'd8, 16'h0000, ST_OK}});
        add_row('{KIND_POP,  12'd8,    16'h0000, 1'b1, '{12'd9, 16'hFFFF, ST_OK}});
        add_row('{KIND_POP,  12'd9,    16'h0000, 1'b1, '{12'd0, 16'h0000, ST_EMPTY}});
        add_row('{KIND_PUSH, 12'd2,    16'hAAAA, 1'b0, '0});
        add_row('{KIND_POP,  12'd3,    16'h0000, 1'b0, '0});
        add_row('{KIND_PUSH, 12'd0,    16'h5555, 1'b0, '0});
        add_row('{KIND_PUSH, 12'd2048, 16'h0000, 1'b1,
                  '{12'd0, 16'h0000, ST_BAD_VERSION}});
        add_row('{KIND_POP,  12'hAAA,  16'h0000, 1'b1,
                  '{12'd0, 16'h0000, ST_BAD_VERSION}});
        add_row('{KIND_PUSH, 12'h555,  16'h0000, 1'b1,
                  '{12'd0, 16'h0000, ST_BAD_VERSION}});
        add_row('{KIND_POP,  12'd4,    16'h0000, 1'b0, '0});
        add_row('{KIND_PUSH, 12'd12,   16'h7FFF, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (op_table[i])
            send_req(op_table[i].kind, op_table[i].version, op_table[i].value,
                     op_table[i].typed, op_table[i].rsp);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS - TAIL_OPS) begin
                // last stretch at full rate
                req_idle_on  = 1'b0;
                rsp_stall_on = 1'b0;
            end else if (n < RANDOM_OPS - TAIL_OPS && n % 100 == 0) begin
                req_idle_on  = ($urandom_range(0, 3) != 0);
                rsp_stall_on = ($urandom_range(0, 3) != 0);
            end
            send_random(1'b1);
        end

        @(negedge i_clk);
        req_bus.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS versioned_stack_store");
        end else begin
            $display("FAIL versioned_stack_store");
        end
        $finish;
    end

endmodule
